// ===== rtl/lzc_pkg.sv =====
`default_nettype none
package lzc_pkg;

    localparam int PHRASE_W = 13;
    localparam int BYTE_W = 8;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // One outgoing pair as it sits in the output register.
    typedef struct packed {
        logic [PHRASE_W-1:0] phrase_index;
        logic [BYTE_W-1:0]   next_byte;
        logic                byte_present;
        logic                final_pair;
    } pair_t;

endpackage
`default_nettype wire

// ===== rtl/lzc_ram.sv =====
`default_nettype none
module lzc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/lz78_stream_compressor_unit.sv =====
`default_nettype none
// LZ78 compressor: one text byte per request in, zero or one (phrase, byte) pair out.
// The scan reads one entry a cycle from the single dictionary memory, at most the
// current entry count, and stops at the first hit. A new byte is taken only after the
// last one is finished, which waits for any held output pair to be taken.
// Reset (rst_n low, asynchronous) empties the dictionary and the current phrase at once.
// No clearing pass runs: an entry count bounds every dictionary read.
module lz78_stream_compressor_unit #(
    parameter int DICT_ENTRIES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // message_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [12:0] phrase_index, [20:13] next_byte,
                                        // [21] byte_present, [23:22] zero
    output logic             m_tlast    // final_pair
);

    localparam int AW = $clog2(DICT_ENTRIES);
    localparam int IW = $clog2(DICT_ENTRIES + 1);
    localparam int MW = IW + lzc_pkg::BYTE_W;
    localparam logic [IW-1:0] FULL = IW'(DICT_ENTRIES);

    lzc_pkg::state_t state_reg, state_next;
    logic [IW-1:0] count_reg, count_next;
    logic [IW-1:0] phrase_reg, phrase_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;
    logic          ovalid_reg, ovalid_next;
    lzc_pkg::pair_t pair_reg, pair_next;

    logic          mem_we;
    logic [MW-1:0] mem_rdata;
    logic          match;
    logic          issue;
    logic          out_free;
    logic [31:0]   wide_phrase;
    logic [31:0]   wide_hit;

    lzc_ram #(
        .WIDTH(MW),
        .DEPTH(DICT_ENTRIES)
    ) u_dict (
        .clk  (clk),
        .we   (mem_we),
        .waddr(count_reg[AW-1:0]),
        .wdata({phrase_reg, byte_reg}),
        .raddr(scan_reg[AW-1:0]),
        .rdata(mem_rdata)
    );

    assign match = rd_pend_reg && (mem_rdata == {phrase_reg, byte_reg});
    assign issue = (state_reg == lzc_pkg::ST_SCAN) && !match && (scan_reg < count_reg);
    assign out_free = !ovalid_reg || m_tready;
    assign mem_we = (state_reg == lzc_pkg::ST_FINISH) && out_free && !hit_reg
                    && (count_reg < FULL);
    assign wide_phrase = 32'(phrase_reg);
    assign wide_hit = 32'(hit_idx_reg);

    assign s_tready = (state_reg == lzc_pkg::ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata = {2'b00, pair_reg.byte_present, pair_reg.next_byte,
                      pair_reg.phrase_index};
    assign m_tlast = pair_reg.final_pair;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        phrase_next = phrase_reg;
        scan_next = scan_reg;
        rd_idx_next = rd_idx_reg;
        rd_pend_next = 1'b0;
        hit_next = hit_reg;
        hit_idx_next = hit_idx_reg;
        byte_next = byte_reg;
        last_next = last_reg;
        ovalid_next = ovalid_reg && !m_tready;
        pair_next = pair_reg;
        case (state_reg)
            lzc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next = s_tdata;
                    last_next = s_tlast;
                    scan_next = '0;
                    hit_next = 1'b0;
                    state_next = lzc_pkg::ST_SCAN;
                end
            end
            lzc_pkg::ST_SCAN:
            begin
                if (match)
                begin
                    hit_next = 1'b1;
                    hit_idx_next = rd_idx_reg + IW'(1);
                    state_next = lzc_pkg::ST_FINISH;
                end
                else if (issue)
                begin
                    rd_pend_next = 1'b1;
                    rd_idx_next = scan_reg;
                    scan_next = scan_reg + IW'(1);
                end
                else
                begin
                    // Any read still pending has just been compared and missed.
                    state_next = lzc_pkg::ST_FINISH;
                end
            end
            lzc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    if (hit_reg)
                    begin
                        phrase_next = hit_idx_reg;
                        pair_next.phrase_index = wide_hit[lzc_pkg::PHRASE_W-1:0];
                        pair_next.next_byte = '0;
                        pair_next.byte_present = 1'b0;
                        pair_next.final_pair = 1'b1;
                        ovalid_next = last_reg;
                    end
                    else
                    begin
                        pair_next.phrase_index = wide_phrase[lzc_pkg::PHRASE_W-1:0];
                        pair_next.next_byte = byte_reg;
                        pair_next.byte_present = 1'b1;
                        pair_next.final_pair = last_reg;
                        ovalid_next = 1'b1;
                        phrase_next = '0;
                        if (count_reg < FULL)
                        begin
                            count_next = count_reg + IW'(1);
                        end
                    end
                    if (last_reg)
                    begin
                        count_next = '0;
                        phrase_next = '0;
                    end
                    state_next = lzc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lzc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzc_pkg::ST_IDLE;
            count_reg <= '0;
            phrase_reg <= '0;
            rd_pend_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phrase_reg <= phrase_next;
            rd_pend_reg <= rd_pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        rd_idx_reg <= rd_idx_next;
        hit_reg <= hit_next;
        hit_idx_reg <= hit_idx_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        pair_reg <= pair_next;
    end

    // The entry count never passes the dictionary size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("entry count above dictionary size");

    // The current phrase always names an existing entry or the empty phrase.
    a_phrase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phrase_reg <= count_reg)
        else $error("phrase index beyond entry count");

    // A dictionary read is in flight only during the scan.
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> state_reg == lzc_pkg::ST_SCAN)
        else $error("dictionary read outside scan");

    // A request is taken only when the scan engine is idle, and a scan follows.
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == lzc_pkg::ST_SCAN)
        else $error("accepted byte did not start a scan");

endmodule
`default_nettype wire

// ===== sim/lz78_pair_checker.sv =====
module lz78_pair_checker #(
    parameter int DICT_ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_pairs
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [lzc_pkg::PHRASE_W-1:0] phrase_index;
        logic [lzc_pkg::BYTE_W-1:0]   next_byte;
        logic                         byte_present;
        logic                         final_pair;
    } lz_pair_t;

    logic [lzc_pkg::PHRASE_W-1:0] dict_prefix [DICT_ENTRIES];
    logic [lzc_pkg::BYTE_W-1:0]   dict_byte [DICT_ENTRIES];
    int unsigned                  dict_used;
    logic [lzc_pkg::PHRASE_W-1:0] phrase;
    lz_pair_t                     pair_queue [$];

    assign pending_pairs = pair_queue.size();

    // Mirrors one byte through the dictionary and queues any pair it produces.
    task automatic compress_byte(input logic [7:0] b, input logic last);
        int unsigned hit;
        lz_pair_t    p;
        hit = 0;
        for (int unsigned j = 0; j < dict_used; j++) begin
            if (dict_prefix[j] == phrase && dict_byte[j] == b) begin
                hit = j + 1;
                break;
            end
        end
        if (hit != 0) begin
            phrase = hit[lzc_pkg::PHRASE_W-1:0];
            if (last) begin
                p = '{phrase, 8'd0, 1'b0, 1'b1};
                pair_queue.push_back(p);
            end
        end else begin
            p = '{phrase, b, 1'b1, last};
            pair_queue.push_back(p);
            if (dict_used < DICT_ENTRIES) begin
                dict_prefix[dict_used] = phrase;
                dict_byte[dict_used] = b;
                dict_used++;
            end
            phrase = '0;
        end
        if (last) begin
            dict_used = 0;
            phrase = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        lz_pair_t got;
        lz_pair_t want;
        if (!rst_n) begin
            dict_used = 0;
            phrase = '0;
            pair_queue.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[12:0], m_tdata[20:13], m_tdata[21], m_tlast};
                if (pair_queue.size() == 0) begin
                    $display("%0t: unexpected pair %h", $time, got);
                    fail_count++;
                end else begin
                    want = pair_queue.pop_front();
                    if (got !== want || m_tdata[23:22] !== 2'b00) begin
                        $display("%0t: pair mismatch expected idx=%0d byte=%h pres=%b fin=%b",
                                 $time, want.phrase_index, want.next_byte,
                                 want.byte_present, want.final_pair);
                        $display("%0t:               actual idx=%0d byte=%h pres=%b fin=%b pad=%b",
                                 $time, got.phrase_index, got.next_byte,
                                 got.byte_present, got.final_pair, m_tdata[23:22]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                compress_byte(s_tdata, s_tlast);
        end
    end
endmodule

// ===== sim/tb_lz78_stream_compressor_unit.sv =====
module tb_lz78_stream_compressor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending_pairs;
    int          send_idle_pct;
    int          recv_stall_pct;
    longint      cycle_count;

    lz78_stream_compressor_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    lz78_pair_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_pairs(pending_pairs)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Scans grow with the dictionary and stalls stretch every byte, so the limit is wide.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 20000000) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each call leaves tvalid high; within a call it drops only while the sender idles.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Messages from a small alphabet repeat phrases, which exercises long matches.
    task automatic send_message(input int len, input int alpha);
        for (int i = 0; i < len; i++)
            send_byte(alpha == 0 ? 8'($urandom) : 8'($urandom_range(alpha - 1)),
                      i == len - 1);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_pairs != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial begin
        int sent;
        int len;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero and all-ones bytes, a last byte that matches, one that does not.
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'haa, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        drain();

        // One long message over a single symbol grows chained phrases of rising length.
        send_message(100, 1);
        drain();

        sent = 0;
        for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
            case (phase_idx)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (int k = 0; k < 430; k += len) begin
                len = $urandom_range(1, 60);
                send_message(len, $urandom_range(3) == 0 ? 0 : $urandom_range(1, 6));
            end
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
